// File: sv/pythagorean_sum_core_macros.svh
// Assertion macros used by the top-level RTL file of the pythagorean sum core.
`ifndef PYTHAGOREAN_SUM_CORE_MACROS_SVH
`define PYTHAGOREAN_SUM_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PYS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PYS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pys_pkg.sv
// Package: shared constants and types of the pythagorean sum core.
`default_nettype none
package pys_pkg;
  localparam int ITERATION_COUNT = 3;
  localparam int ValW  = 48;   // Q32.16 working value
  localparam int FracW = 32;   // Q0.32 ratio and t
  localparam int LegW  = 32;

  typedef struct packed {
    logic [ValW-1:0] p;
    logic [ValW-1:0] q;
  } ctx_t;
endpackage
`default_nettype wire

// File: sv/pythagorean_sum_core.sv
// Top level: streaming hypotenuse length core (Moler-Morrison iteration).
// Usage:
//  - Input channel in_*: one transaction carries the two signed 32-bit legs
//    x_value (in_tdata[31:0]) and y_value (in_tdata[63:32]).
//  - Result channel out_*: one transaction per input, magnitude in
//    out_tdata[47:0], unsigned Q32.16, truncated; results keep input order.
//  - Each round has two bit-serial pipelined dividers (32 stages each
//    plus an entry stage) and four multiply/add stages.
//  - Throughput: one transaction per cycle while in_tready is high; every
//    stage holds its own item.
//  - Stall: the pipeline advances as one; an output register plus a skid
//    register sit after it, so with out_tready low the pipeline keeps
//    flowing until the skid fills, then in_tready drops. Nothing is lost
//    or repeated.
//  - Reset (rst_n low, synchronous): all valid bits clear, in-flight
//    transactions are dropped; in_tready is high right after.
//  - Both legs zero give a magnitude of zero.
`default_nettype none
`include "pythagorean_sum_core_macros.svh"
module pythagorean_sum_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] x_value, [63:32] y_value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata   // [47:0] magnitude
);
  localparam int NIt = pys_pkg::ITERATION_COUNT;

  logic en;          // whole pipeline advances
  logic skid_v_r;
  logic [47:0] skid_d_r;
  logic out_v_r;
  logic [47:0] out_d_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  // magnitudes, larger first, scaled to Q32.16
  logic [pys_pkg::LegW-1:0] ax_w, ay_w, big_w, sml_w;
  always_comb begin
    ax_w  = in_tdata[31] ? (~in_tdata[31:0] + 32'd1) : in_tdata[31:0];
    ay_w  = in_tdata[63] ? (~in_tdata[63:32] + 32'd1) : in_tdata[63:32];
    big_w = (ax_w < ay_w) ? ay_w : ax_w;
    sml_w = (ax_w < ay_w) ? ax_w : ay_w;
  end

  logic          vld_s [0:NIt];
  pys_pkg::ctx_t ctx_s [0:NIt];
  logic          in_vld_r;
  pys_pkg::ctx_t in_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_tvalid;
    end
    if (en) begin
      in_ctx_r.p <= {big_w, 16'd0};
      in_ctx_r.q <= {sml_w, 16'd0};
    end
  end

  assign vld_s[0] = in_vld_r;
  assign ctx_s[0] = in_ctx_r;

  for (genvar i = 0; i < NIt; i++) begin : g_iter
    pys_iter u_iter (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(vld_s[i]), .in_ctx(ctx_s[i]),
      .out_valid(vld_s[i+1]), .out_ctx(ctx_s[i+1])
    );
  end

  // output register with skid
  logic push, pop;
  assign push = vld_s[NIt] && en;
  assign pop  = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        out_v_r  <= 1'b1;
        out_d_r  <= skid_d_r;
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_v_r <= 1'b1;
        out_d_r <= ctx_s[NIt].p;
      end else begin
        skid_v_r <= 1'b1;
        skid_d_r <= ctx_s[NIt].p;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

  `PYS_ASSERT_NOW(a_skid_needs_out, skid_v_r, out_v_r, "skid full with empty output")
  `PYS_ASSERT_NOW(a_skid_blocks_in, skid_v_r, !in_tready, "input open while skid full")
  `PYS_ASSERT_NEXT(a_skid_drains, skid_v_r && out_tready, out_v_r && !skid_v_r,
    "skid entry not moved to output")
endmodule
`default_nettype wire

// File: sv/pys_frac_div.sv
// Pipelined fraction divider: quo = floor(num * 2^32 / den), one bit per stage.
`default_nettype none
module pys_frac_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic [pys_pkg::ValW-1:0]          in_num,
  input  wire logic [pys_pkg::ValW-1:0]          in_den,
  input  wire pys_pkg::ctx_t                     in_ctx,
  output logic                                   out_valid,
  output logic [pys_pkg::FracW-1:0]              out_quo,
  output pys_pkg::ctx_t                          out_ctx
);
  localparam int NStg = pys_pkg::FracW;

  logic                         vld_r [0:NStg];
  logic                         sat_r [0:NStg];
  logic [pys_pkg::ValW-1:0]     rem_r [0:NStg];
  logic [pys_pkg::ValW-1:0]     den_r [0:NStg];
  logic [pys_pkg::FracW-1:0]    quo_r [0:NStg];
  pys_pkg::ctx_t                ctx_r [0:NStg];

  // entry stage; num >= den saturates the quotient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
    if (en) begin
      sat_r[0] <= (in_num >= in_den);
      rem_r[0] <= in_num;
      den_r[0] <= in_den;
      quo_r[0] <= '0;
      ctx_r[0] <= in_ctx;
    end
  end

  for (genvar k = 0; k < NStg; k++) begin : g_bit
    logic [pys_pkg::ValW:0]   sh_w;
    logic                     ge_w;
    logic [pys_pkg::ValW-1:0] rem_nxt;

    always_comb begin
      sh_w    = {rem_r[k], 1'b0};
      ge_w    = (sh_w >= {1'b0, den_r[k]});
      rem_nxt = ge_w ? pys_pkg::ValW'(sh_w - {1'b0, den_r[k]})
                     : sh_w[pys_pkg::ValW-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
      if (en) begin
        sat_r[k+1] <= sat_r[k];
        rem_r[k+1] <= rem_nxt;
        den_r[k+1] <= den_r[k];
        quo_r[k+1] <= {quo_r[k][pys_pkg::FracW-2:0], ge_w};
        ctx_r[k+1] <= ctx_r[k];
      end
    end
  end

  assign out_valid = vld_r[NStg];
  assign out_quo   = sat_r[NStg] ? '1 : quo_r[NStg];
  assign out_ctx   = ctx_r[NStg];
endmodule
`default_nettype wire

// File: sv/pys_iter.sv
// One Moler-Morrison round: r=q/p, s=r*r, t=s/(4+s), p+=2pt, q*=t.
`default_nettype none
module pys_iter (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire pys_pkg::ctx_t in_ctx,
  output logic               out_valid,
  output pys_pkg::ctx_t      out_ctx
);
  localparam logic [pys_pkg::ValW-1:0] Four = pys_pkg::ValW'(64'h4_0000_0000);

  logic                       d1_vld;
  logic [pys_pkg::FracW-1:0]  d1_r;
  pys_pkg::ctx_t              d1_ctx;

  pys_frac_div u_div_r (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_valid), .in_num(in_ctx.q), .in_den(in_ctx.p), .in_ctx(in_ctx),
    .out_valid(d1_vld), .out_quo(d1_r), .out_ctx(d1_ctx)
  );

  // s = r*r / 2^32
  logic          m1_vld_r;
  logic [63:0]   m1_sq_r;
  pys_pkg::ctx_t m1_ctx_r;
  logic [pys_pkg::ValW-1:0] s_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= d1_vld;
    end
    if (en) begin
      m1_sq_r  <= 64'(d1_r) * 64'(d1_r);
      m1_ctx_r <= d1_ctx;
    end
  end

  assign s_w = pys_pkg::ValW'(m1_sq_r[63:32]);

  logic                       d2_vld;
  logic [pys_pkg::FracW-1:0]  d2_t;
  pys_pkg::ctx_t              d2_ctx;

  pys_frac_div u_div_t (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(m1_vld_r), .in_num(s_w), .in_den(Four + s_w), .in_ctx(m1_ctx_r),
    .out_valid(d2_vld), .out_quo(d2_t), .out_ctx(d2_ctx)
  );

  // partial products of p*t and q*t
  logic          m2_vld_r;
  logic [63:0]   m2_plo_r, m2_qlo_r;
  logic [47:0]   m2_phi_r, m2_qhi_r;
  pys_pkg::ctx_t m2_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m2_vld_r <= d2_vld;
    end
    if (en) begin
      m2_plo_r <= 64'(d2_ctx.p[31:0]) * 64'(d2_t);
      m2_phi_r <= 48'(d2_ctx.p[47:32]) * 48'(d2_t);
      m2_qlo_r <= 64'(d2_ctx.q[31:0]) * 64'(d2_t);
      m2_qhi_r <= 48'(d2_ctx.q[47:32]) * 48'(d2_t);
      m2_ctx_r <= d2_ctx;
    end
  end

  // p increment = p*t/2^31, new q = q*t/2^32
  logic          a_vld_r;
  logic [49:0]   a_pinc_r;
  logic [48:0]   a_qn_r;
  pys_pkg::ctx_t a_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= m2_vld_r;
    end
    if (en) begin
      a_pinc_r <= 50'({m2_phi_r, 1'b0}) + 50'(m2_plo_r[63:31]);
      a_qn_r   <= 49'(m2_qhi_r) + 49'(m2_qlo_r[63:32]);
      a_ctx_r  <= m2_ctx_r;
    end
  end

  logic          b_vld_r;
  pys_pkg::ctx_t b_ctx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
    if (en) begin
      b_ctx_r.p <= pys_pkg::ValW'(50'(a_ctx_r.p) + a_pinc_r);
      b_ctx_r.q <= a_qn_r[pys_pkg::ValW-1:0];
    end
  end

  assign out_valid = b_vld_r;
  assign out_ctx   = b_ctx_r;
endmodule
`default_nettype wire
